// ----- hdl/eno3_pkg.sv -----
// Shared definitions for the ENO3 face reconstruction block.
// Holds the default sample width, the window depth and the stencil codes.
// No dependencies.
package eno3_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int WIN_DEPTH        = 5;
  localparam int FILL_W           = 3;
  localparam int NUM_LANES        = 2;
  localparam int LANE_RIGHT       = 0;
  localparam int LANE_LEFT        = 1;

  typedef enum logic [1:0] {
    STENCIL_LEFT,
    STENCIL_CENTRE,
    STENCIL_RIGHT
  } stencil_e;

endpackage

// ----- hdl/eno3_window.sv -----
// Sample window and fill count, followed by the first pipeline register.
// Depends on eno3_pkg.
module eno3_window #(
  parameter int SW = eno3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [SW-1:0]                       sample_i,
  input  logic                                row_start_i,
  input  logic                                row_end_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [eno3_pkg::WIN_DEPTH:0][SW-1:0] samples_o,
  output logic                                last_o
);
  import eno3_pkg::*;

  logic [SW-1:0]              win_q [WIN_DEPTH];
  logic [FILL_W-1:0]          fill_q, fill_d, fill_eff;
  logic [WIN_DEPTH:0][SW-1:0] u_q, u_d;
  logic                       last_q;
  logic                       valid_q;
  logic                       accept;
  logic                       produce;

  assign ready_o  = !valid_q || ready_i;
  assign accept   = valid_i && ready_o;
  assign fill_eff = row_start_i ? '0 : fill_q;
  assign produce  = (fill_eff == FILL_W'(WIN_DEPTH));

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (produce) begin
        fill_d = fill_eff;
      end else begin
        fill_d = fill_eff + FILL_W'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      u_d[i] = win_q[i];
    end
    u_d[WIN_DEPTH] = sample_i;
  end

  // Entries left over from an earlier row are overwritten before the count reaches full.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_DEPTH-1] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (ready_o) begin
        valid_q <= accept && produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      u_q    <= u_d;
      last_q <= row_end_i;
    end
  end

  assign valid_o   = valid_q;
  assign samples_o = u_q;
  assign last_o    = last_q;

endmodule

// ----- hdl/eno3_select.sv -----
// Stencil selection stage: picks the smoothest stencil for both faces.
// Depends on eno3_pkg.
module eno3_select #(
  parameter int SW = eno3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [eno3_pkg::WIN_DEPTH:0][SW-1:0] samples_i,
  input  logic                                last_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [eno3_pkg::WIN_DEPTH:0][SW-1:0] samples_o,
  output eno3_pkg::stencil_e                  sr_o,
  output eno3_pkg::stencil_e                  sl_o,
  output logic                                last_o
);
  import eno3_pkg::*;

  localparam int D1W = SW + 1;
  localparam int D2W = SW + 2;

  logic [WIN_DEPTH:0][SW-1:0] samples_q;
  stencil_e                   sr_q, sr_d, sl_q, sl_d;
  logic                       last_q;
  logic                       valid_q;

  function automatic logic [D1W-1:0] abs1(input logic signed [D1W-1:0] x);
    return x[D1W-1] ? D1W'(-x) : D1W'(x);
  endfunction

  function automatic logic [D2W-1:0] abs2(input logic signed [D2W-1:0] x);
    return x[D2W-1] ? D2W'(-x) : D2W'(x);
  endfunction

  function automatic stencil_e pick(input logic signed [SW-1:0] p0, input logic signed [SW-1:0] p1,
                                    input logic signed [SW-1:0] p2, input logic signed [SW-1:0] p3,
                                    input logic signed [SW-1:0] p4);
    logic [D1W-1:0] a1l, a1r;
    logic [D2W-1:0] a2l, a2c, a2r;
    a1l = abs1(D1W'(p2) - D1W'(p1));
    a1r = abs1(D1W'(p3) - D1W'(p2));
    a2l = abs2(D2W'(p2) - (D2W'(p1) <<< 1) + D2W'(p0));
    a2c = abs2(D2W'(p3) - (D2W'(p2) <<< 1) + D2W'(p1));
    a2r = abs2(D2W'(p4) - (D2W'(p3) <<< 1) + D2W'(p2));
    if (a1l <= a1r) begin
      return (a2l <= a2c) ? STENCIL_LEFT : STENCIL_CENTRE;
    end
    return (a2c <= a2r) ? STENCIL_CENTRE : STENCIL_RIGHT;
  endfunction

  assign ready_o = !valid_q || ready_i;

  assign sr_d = pick(samples_i[0], samples_i[1], samples_i[2], samples_i[3], samples_i[4]);
  assign sl_d = pick(samples_i[1], samples_i[2], samples_i[3], samples_i[4], samples_i[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      samples_q <= samples_i;
      sr_q      <= sr_d;
      sl_q      <= sl_d;
      last_q    <= last_i;
    end
  end

  assign valid_o   = valid_q;
  assign samples_o = samples_q;
  assign sr_o      = sr_q;
  assign sl_o      = sl_q;
  assign last_o    = last_q;

endmodule

// ----- hdl/eno3_face.sv -----
// Face sum stage: forms the weighted stencil sums and their rounded halves.
// Depends on eno3_pkg.
module eno3_face #(
  parameter int SW = eno3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [eno3_pkg::WIN_DEPTH:0][SW-1:0]    samples_i,
  input  eno3_pkg::stencil_e                     sr_i,
  input  eno3_pkg::stencil_e                     sl_i,
  input  logic                                   last_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [eno3_pkg::NUM_LANES-1:0]          neg_o,
  output logic [eno3_pkg::NUM_LANES-1:0][SW+2:0]  half_o,
  output logic                                   last_o
);
  import eno3_pkg::*;

  localparam int SUMW = SW + 5;
  localparam int AW   = SW + 4;
  localparam int NW   = SW + 3;
  localparam logic signed [SUMW-1:0] K2  = SUMW'(2);
  localparam logic signed [SUMW-1:0] K5  = SUMW'(5);
  localparam logic signed [SUMW-1:0] K7  = SUMW'(7);
  localparam logic signed [SUMW-1:0] K11 = SUMW'(11);
  localparam logic [AW-1:0]          ROUND_ADD = AW'(3);

  logic signed [SUMW-1:0]        e [WIN_DEPTH+1];
  logic signed [SUMW-1:0]        sum [NUM_LANES];
  logic [NUM_LANES-1:0]          neg_d, neg_q;
  logic [NUM_LANES-1:0][NW-1:0]  half_d, half_q;
  logic [AW-1:0]                 mag [NUM_LANES];
  logic                          last_q;
  logic                          valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int i = 0; i <= WIN_DEPTH; i++) begin
      e[i] = SUMW'($signed(samples_i[i]));
    end
  end

  always_comb begin
    unique case (sr_i)
      STENCIL_LEFT:   sum[LANE_RIGHT] = K2 * e[0] - K7 * e[1] + K11 * e[2];
      STENCIL_CENTRE: sum[LANE_RIGHT] = K5 * e[2] + K2 * e[3] - e[1];
      STENCIL_RIGHT:  sum[LANE_RIGHT] = K2 * e[2] + K5 * e[3] - e[4];
      default:        sum[LANE_RIGHT] = '0;
    endcase
  end

  // The left face of cell j+1 uses the mirror image of the stencil chosen around j+1.
  always_comb begin
    unique case (sl_i)
      STENCIL_LEFT:   sum[LANE_LEFT] = K2 * e[3] + K5 * e[2] - e[1];
      STENCIL_CENTRE: sum[LANE_LEFT] = K5 * e[3] + K2 * e[2] - e[4];
      STENCIL_RIGHT:  sum[LANE_LEFT] = K2 * e[5] - K7 * e[4] + K11 * e[3];
      default:        sum[LANE_LEFT] = '0;
    endcase
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      neg_d[l]  = sum[l][SUMW-1];
      mag[l]    = neg_d[l] ? AW'(-sum[l]) : AW'(sum[l]);
      half_d[l] = NW'((mag[l] + ROUND_ADD) >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q  <= neg_d;
      half_q <= half_d;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign half_o  = half_q;
  assign last_o  = last_q;

endmodule

// ----- hdl/eno3_div6.sv -----
// Division by three of the halved sums, sign restore and saturation, in two stages.
// The second stage is the result register. Depends on eno3_pkg.
module eno3_div6 #(
  parameter int SW = eno3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [eno3_pkg::NUM_LANES-1:0]          neg_i,
  input  logic [eno3_pkg::NUM_LANES-1:0][SW+2:0]  half_i,
  input  logic                                   last_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [eno3_pkg::NUM_LANES-1:0][SW-1:0]  value_o,
  output logic                                   last_o
);
  import eno3_pkg::*;

  localparam int NW = SW + 3;
  localparam int KS = SW + 5;
  localparam int MW = SW + 4;
  localparam int LW = (NW + 1) / 2;
  localparam int HW = NW - LW;
  localparam int QW = SW + 2;
  localparam int FW = NW + MW;
  localparam logic [MW-1:0] RECIP   = MW'(((64'd1 << KS) + 64'd2) / 64'd3);
  localparam logic [QW-1:0] POS_LIM = {3'b000, {(SW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {3'b001, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] MAX_VAL = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] MIN_VAL = {1'b1, {(SW-1){1'b0}}};

  logic [NUM_LANES-1:0][LW+MW-1:0] plo_d, plo_q;
  logic [NUM_LANES-1:0][HW+MW-1:0] phi_d, phi_q;
  logic [NUM_LANES-1:0]            neg_q;
  logic                            last_a_q;
  logic                            valid_a_q;
  logic                            ready_a;
  logic [FW-1:0]                   full [NUM_LANES];
  logic [QW-1:0]                   quo [NUM_LANES];
  logic [NUM_LANES-1:0][SW-1:0]    value_d, value_q;
  logic                            last_q;
  logic                            valid_q;

  assign ready_a = !valid_q || ready_i;
  assign ready_o = !valid_a_q || ready_a;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      plo_d[l] = (LW+MW)'(half_i[l][LW-1:0]) * (LW+MW)'(RECIP);
      phi_d[l] = (HW+MW)'(half_i[l][NW-1:LW]) * (HW+MW)'(RECIP);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      full[l] = (FW'(phi_q[l]) << LW) + FW'(plo_q[l]);
      quo[l]  = full[l][FW-1:KS];
      if (neg_q[l]) begin
        value_d[l] = (quo[l] > NEG_LIM) ? MIN_VAL : (~quo[l][SW-1:0]) + SW'(1);
      end else begin
        value_d[l] = (quo[l] > POS_LIM) ? MAX_VAL : quo[l][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_a_q <= valid_i;
      end
      if (ready_a) begin
        valid_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      neg_q    <= neg_i;
      last_a_q <= last_i;
    end
    if (ready_a && valid_a_q) begin
      value_q <= value_d;
      last_q  <= last_a_q;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign last_o  = last_q;

endmodule

// ----- hdl/eno3_face_reconstruction.sv -----
// Third-order ENO face reconstruction for one stream of cell averages.
// Five register stages: window, selection, face sum, division and result.
// Throughput: one request per cycle while out_ready_i is held high.
// Each stage holds its item while the next is full, so bubbles close up under back-pressure.
// Reset clears the fill count and all stage valid flags; the window needs no clearing pass.
module eno3_face_reconstruction #(
  parameter int SAMPLE_WIDTH = eno3_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    row_start_i,
  input  logic                    row_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0] right_face_value_o,
  output logic [SAMPLE_WIDTH-1:0] left_face_value_o,
  output logic                    last_of_row_o
);
  import eno3_pkg::*;

  logic [WIN_DEPTH:0][SAMPLE_WIDTH-1:0]   win_samples, sel_samples;
  logic                                   win_valid, win_last;
  logic                                   sel_valid, sel_ready, sel_last;
  stencil_e                               sel_sr, sel_sl;
  logic                                   face_valid, face_ready, face_last;
  logic [NUM_LANES-1:0]                   face_neg;
  logic [NUM_LANES-1:0][SAMPLE_WIDTH+2:0] face_half;
  logic                                   div_ready;
  logic [NUM_LANES-1:0][SAMPLE_WIDTH-1:0] div_value;

  eno3_window #(.SW(SAMPLE_WIDTH)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .sample_i    (sample_i),
    .row_start_i (row_start_i),
    .row_end_i   (row_end_i),
    .valid_o     (win_valid),
    .ready_i     (sel_ready),
    .samples_o   (win_samples),
    .last_o      (win_last)
  );

  eno3_select #(.SW(SAMPLE_WIDTH)) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (win_valid),
    .ready_o   (sel_ready),
    .samples_i (win_samples),
    .last_i    (win_last),
    .valid_o   (sel_valid),
    .ready_i   (face_ready),
    .samples_o (sel_samples),
    .sr_o      (sel_sr),
    .sl_o      (sel_sl),
    .last_o    (sel_last)
  );

  eno3_face #(.SW(SAMPLE_WIDTH)) u_face (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sel_valid),
    .ready_o   (face_ready),
    .samples_i (sel_samples),
    .sr_i      (sel_sr),
    .sl_i      (sel_sl),
    .last_i    (sel_last),
    .valid_o   (face_valid),
    .ready_i   (div_ready),
    .neg_o     (face_neg),
    .half_o    (face_half),
    .last_o    (face_last)
  );

  eno3_div6 #(.SW(SAMPLE_WIDTH)) u_div6 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (face_valid),
    .ready_o (div_ready),
    .neg_i   (face_neg),
    .half_i  (face_half),
    .last_i  (face_last),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .value_o (div_value),
    .last_o  (last_of_row_o)
  );

  assign right_face_value_o = div_value[LANE_RIGHT];
  assign left_face_value_o  = div_value[LANE_LEFT];

  // A request that opens a row never yields a result.
  a_row_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && row_start_i |=> !win_valid)
    else $error("row start request produced a result");

  a_window_to_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid && sel_ready |=> sel_valid)
    else $error("item lost between window and selection stages");

  a_ready_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> win_valid && !sel_ready)
    else $error("input stalled while the first stage could advance");

endmodule

// ----- bench/eno3_face_reconstruction_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for eno3_face_reconstruction: directed and random rows of samples.
// Expected face values come from a predictor of the ENO3 window kept inside this bench.
// Depends on eno3_pkg and the eno3_face_reconstruction RTL.
module eno3_face_reconstruction_tb;
  import eno3_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 700;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic [SW-1:0] sample;
    logic          row_start;
    logic          row_end;
  } request_t;

  typedef struct {
    logic [SW-1:0] right;
    logic [SW-1:0] left;
    logic          last;
  } faces_t;

  typedef longint points_t [5];

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [SW-1:0] sample_i = '0;
  logic          row_start_i = 1'b0;
  logic          row_end_i = 1'b0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [SW-1:0] right_face_value_o;
  logic [SW-1:0] left_face_value_o;
  logic          last_of_row_o;

  request_t request_q[$];
  faces_t   faces_q[$];

  logic signed [SW-1:0] window_q [WIN_DEPTH];
  int                   fill_q = 0;

  int mismatch_cnt = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_stall = 0;
  int rx_calm = 0;
  int quiet_cycles = 0;

  eno3_face_reconstruction #(
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .row_start_i       (row_start_i),
    .row_end_i         (row_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .right_face_value_o(right_face_value_o),
    .left_face_value_o (left_face_value_o),
    .last_of_row_o     (last_of_row_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic stencil_e choose_stencil(points_t p);
    longint d2l, d2c, d2r;
    d2l = abs64(p[2] - 2 * p[1] + p[0]);
    d2c = abs64(p[3] - 2 * p[2] + p[1]);
    d2r = abs64(p[4] - 2 * p[3] + p[2]);
    if (abs64(p[2] - p[1]) <= abs64(p[3] - p[2])) begin
      return (d2l <= d2c) ? STENCIL_LEFT : STENCIL_CENTRE;
    end
    return (d2c <= d2r) ? STENCIL_CENTRE : STENCIL_RIGHT;
  endfunction

  function automatic longint stencil_sum(points_t p, stencil_e s);
    case (s)
      STENCIL_LEFT:   return 2 * p[0] - 7 * p[1] + 11 * p[2];
      STENCIL_CENTRE: return -p[1] + 5 * p[2] + 2 * p[3];
      default:        return 2 * p[2] + 5 * p[3] - p[4];
    endcase
  endfunction

  function automatic logic [SW-1:0] div6_saturate(longint s);
    longint q, hi, lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    q = (s >= 0) ? (s + 3) / 6 : -((-s + 3) / 6);
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[SW-1:0];
  endfunction

  task automatic predict_faces(logic [SW-1:0] sample, logic row_start, logic row_end);
    longint   u [6];
    points_t  fwd, mir;
    stencil_e sr, sl, sm;
    faces_t   f;
    if (row_start) begin
      fill_q = 0;
      foreach (window_q[i]) window_q[i] = '0;
    end
    if (fill_q >= WIN_DEPTH) begin
      for (int i = 0; i < WIN_DEPTH; i++) u[i] = longint'(window_q[i]);
      u[5] = longint'($signed(sample));
      for (int i = 0; i < 5; i++) fwd[i] = u[i];
      sr = choose_stencil(fwd);
      f.right = div6_saturate(stencil_sum(fwd, sr));
      for (int i = 0; i < 5; i++) fwd[i] = u[i + 1];
      sl = choose_stencil(fwd);
      for (int i = 0; i < 5; i++) mir[i] = u[5 - i];
      sm = (sl == STENCIL_LEFT) ? STENCIL_RIGHT :
           (sl == STENCIL_RIGHT) ? STENCIL_LEFT : STENCIL_CENTRE;
      f.left = div6_saturate(stencil_sum(mir, sm));
      f.last = row_end;
      faces_q = {faces_q, f};
    end
    for (int i = 0; i < WIN_DEPTH - 1; i++) window_q[i] = window_q[i + 1];
    window_q[WIN_DEPTH - 1] = sample;
    if (fill_q < WIN_DEPTH) fill_q++;
  endtask

  task automatic report_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  task automatic add_request(logic [SW-1:0] sample, logic row_start, logic row_end);
    request_t r;
    r.sample = sample;
    r.row_start = row_start;
    r.row_end = row_end;
    request_q = {request_q, r};
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SW-1:0] row_sample(int style, int idx, logic [SW-1:0] base,
                                               logic [SW-1:0] step);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 16) - 8;
      2: return base + idx * step + ($urandom_range(0, 255) - 128);
      default: begin
        case ($urandom_range(0, 4))
          0: return S_MAX;
          1: return S_MIN;
          2: return S_MAX - 1;
          3: return S_MIN + 1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_faces(sample_i, row_start_i, row_end_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          req = request_q.pop_front();
          sample_i <= req.sample;
          row_start_i <= req.row_start;
          row_end_i <= req.row_end;
          in_valid_i <= 1'b1;
          tx_gap = idle_len(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    faces_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (faces_q.size() == 0) begin
          report_mismatch("unexpected result", right_face_value_o, '0);
        end else begin
          want = faces_q.pop_front();
          if (right_face_value_o !== want.right)
            report_mismatch("right_face_value", right_face_value_o, want.right);
          if (left_face_value_o !== want.left)
            report_mismatch("left_face_value", left_face_value_o, want.left);
          if (last_of_row_o !== want.last)
            report_mismatch("last_of_row", SW'(last_of_row_o), SW'(want.last));
        end
        rx_stall = idle_len(rx_calm);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int count, kind, len, style;
    logic [SW-1:0] base, step;
    logic rs, re;

    foreach (window_q[i]) window_q[i] = '0;

    // Alternating extremes drive the sums into saturation; an early row end gives no result.
    add_request(S_MAX, 1'b1, 1'b0);
    add_request(S_MIN, 1'b0, 1'b0);
    add_request(S_MAX, 1'b0, 1'b1);
    add_request(S_MIN, 1'b0, 1'b0);
    add_request(S_MAX, 1'b0, 1'b0);
    add_request(S_MIN, 1'b0, 1'b0);
    add_request(S_MAX, 1'b0, 1'b0);
    add_request(S_MIN, 1'b0, 1'b1);
    // The row carries on without a start flag.
    add_request('0, 1'b0, 1'b0);
    add_request('1, 1'b0, 1'b0);
    add_request(1, 1'b0, 1'b1);
    // Small values hit rounding ties of both signs.
    add_request(-3, 1'b1, 1'b0);
    add_request(3, 1'b0, 1'b0);
    add_request(-3, 1'b0, 1'b0);
    add_request(3, 1'b0, 1'b0);
    add_request(0, 1'b0, 1'b0);
    add_request(3, 1'b0, 1'b0);
    add_request(-3, 1'b0, 1'b1);
    add_request(32'h0001_0000, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) add_request(S_MIN, (i == 0), (i == 5));

    count = 0;
    while (count < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      len = (kind < 85) ? $urandom_range(6, 30) : $urandom_range(1, 8);
      style = $urandom_range(0, 3);
      base = $urandom;
      step = ($urandom_range(0, 2000) - 1000) <<< 8;
      for (int i = 0; i < len; i++) begin
        rs = (i == 0) && (kind < 92);
        re = (i == len - 1) ? (kind < 95) : ($urandom_range(0, 49) == 0);
        add_request(row_sample(style, i, base, step), rs, re);
      end
      count += len;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (faces_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/eno3_pkg.sv
hdl/eno3_window.sv
hdl/eno3_select.sv
hdl/eno3_face.sv
hdl/eno3_div6.sv
hdl/eno3_face_reconstruction.sv
bench/eno3_face_reconstruction_tb.sv
